/* rtl/core/symbol_hash_table_resolver_unit_macros.svh */
// Assertion macros for the symbol hash table resolver RTL (used by shtr_search).
// Expects signals named clock and reset in the module that uses them.
`ifndef SYMBOL_HASH_TABLE_RESOLVER_UNIT_MACROS_SVH
`define SYMBOL_HASH_TABLE_RESOLVER_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SHTR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SHTR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/shtr_pkg.sv */
// Package for the symbol hash table resolver: sizes, codes and payload types.
// Used by every module in rtl/core; depends on nothing.
package shtr_pkg;

   localparam int TableDepth    = 1024;
   localparam int IdxWidth      = $clog2(TableDepth);
   localparam int CntWidth      = $clog2(TableDepth + 1);
   localparam int CfgCountWidth = 11;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 11;
   localparam int HashShift     = 5;

   localparam logic [31:0] HashSeed     = 32'h0000_1505;
   localparam logic [31:0] NotFoundAddr = 32'hFFFF_FFFF;

   localparam logic KindLoad = 1'b0;
   localparam logic KindName = 1'b1;

   localparam logic [CsrIndexWidth-1:0] CsrCacheReady = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrEntryCount = 1'd1;

   typedef struct packed {
      logic        kind;
      logic [9:0]  entry_index;
      logic [31:0] entry_address;
      logic [31:0] entry_hash;
      logic [7:0]  name_char;
   } shtr_req_type;

   typedef struct packed {
      logic [31:0] symbol_address;
      logic        found;
   } shtr_rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] address;
   } shtr_entry_type;

   typedef struct packed {
      logic        start;
      logic [31:0] key;
   } shtr_search_cmd_type;

   typedef struct packed {
      logic         idle;
      logic         valid;
      shtr_rsp_type data;
   } shtr_search_status_type;

endpackage

/* rtl/core/shtr_table_ram.sv */
// Table memory holding (hash, address) pairs: one write port, one read port,
// registered read data. Depends on shtr_pkg.
module shtr_table_ram (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [shtr_pkg::IdxWidth-1:0]         wr_addr,
   input  shtr_pkg::shtr_entry_type              wr_data,
   input  logic                                  rd_en,
   input  logic [shtr_pkg::IdxWidth-1:0]         rd_addr,
   output shtr_pkg::shtr_entry_type              rd_data
);

   shtr_pkg::shtr_entry_type mem [0:shtr_pkg::TableDepth-1];
   shtr_pkg::shtr_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/shtr_search.sv */
// Binary search sequencer over the table memory; holds the result until the
// output register takes it. Depends on shtr_pkg and the assertion macro header.
`include "symbol_hash_table_resolver_unit_macros.svh"

module shtr_search (
   input  logic                                  clock,
   input  logic                                  reset,
   input  shtr_pkg::shtr_search_cmd_type         cmd,
   input  logic                                  cache_ready,
   input  logic [shtr_pkg::CfgCountWidth-1:0]    entry_count,
   output logic                                  rd_en,
   output logic [shtr_pkg::IdxWidth-1:0]         rd_addr,
   input  shtr_pkg::shtr_entry_type              rd_data,
   input  logic                                  out_free,
   output shtr_pkg::shtr_search_status_type      status
);

   localparam logic [1:0] StIdle    = 2'd0;
   localparam logic [1:0] StIssue   = 2'd1;
   localparam logic [1:0] StCompare = 2'd2;
   localparam logic [1:0] StHold    = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [shtr_pkg::CntWidth-1:0]   lo_ff, lo_in;
   logic [shtr_pkg::CntWidth-1:0]   hi_ff, hi_in;
   logic [shtr_pkg::CntWidth-1:0]   mid_ff, mid_in;
   logic [31:0]                     key_ff, key_in;
   shtr_pkg::shtr_rsp_type          res_ff, res_in;
   logic [shtr_pkg::CntWidth-1:0]   count_sat;
   logic [shtr_pkg::CntWidth-1:0]   mid;
   logic                            range_open;

   // Counts above the table depth are clamped to the depth.
   assign count_sat = (32'(entry_count) > shtr_pkg::TableDepth)
                      ? shtr_pkg::CntWidth'(shtr_pkg::TableDepth)
                      : shtr_pkg::CntWidth'(entry_count);

   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign range_open = (lo_ff < hi_ff);
   assign rd_en      = (state_ff == StIssue) && range_open;
   assign rd_addr    = mid[shtr_pkg::IdxWidth-1:0];

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      case (state_ff)
         StIdle: begin
            if (cmd.start) begin
               key_in = cmd.key;
               lo_in  = '0;
               hi_in  = count_sat;
               if (cache_ready) begin
                  state_in = StIssue;
               end else begin
                  res_in   = '{symbol_address: shtr_pkg::NotFoundAddr, found: 1'b0};
                  state_in = StHold;
               end
            end
         end
         StIssue: begin
            if (range_open) begin
               mid_in   = mid;
               state_in = StCompare;
            end else begin
               res_in   = '{symbol_address: shtr_pkg::NotFoundAddr, found: 1'b0};
               state_in = StHold;
            end
         end
         StCompare: begin
            if (rd_data.key == key_ff) begin
               res_in   = '{symbol_address: rd_data.address, found: 1'b1};
               state_in = StHold;
            end else begin
               if (key_ff < rd_data.key) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + shtr_pkg::CntWidth'(1);
               end
               state_in = StIssue;
            end
         end
         StHold: begin
            if (out_free) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

   assign status.idle  = (state_ff == StIdle);
   assign status.valid = (state_ff == StHold);
   assign status.data  = res_ff;

   `SHTR_ASSERT_NOW(a_bounds_ordered, (state_ff == StIssue) || (state_ff == StCompare), (lo_ff <= hi_ff) && (hi_ff <= shtr_pkg::CntWidth'(shtr_pkg::TableDepth)), "search bounds out of order")
   `SHTR_ASSERT_NEXT(a_read_then_compare, rd_en, state_ff == StCompare, "memory read not followed by compare")
   `SHTR_ASSERT_NEXT(a_hold_stable, (state_ff == StHold) && !out_free, (state_ff == StHold) && $stable(res_ff), "held result changed before it was taken")
   `SHTR_ASSERT_NOW(a_start_when_idle, cmd.start, state_ff == StIdle, "lookup started while search busy")

endmodule

/* rtl/core/symbol_hash_table_resolver_unit.sv */
// Top level of the symbol hash table resolver: handshakes, running hash,
// configuration registers and result register. Depends on shtr_pkg,
// shtr_table_ram and shtr_search.

// A load request writes one (hash, address) slot; a nonzero name byte folds
// into the running hash (h*33 + c). A zero byte hands the hash to the binary
// search (or, while the table is not marked ready, gives a miss at once),
// which owns the only read port of the table memory: each probe first issues
// an address, then compares the registered read data with the key. While the
// search runs, and while a result waits for a free output register, no request
// is accepted. The table has no clear pass: slots must be loaded before a
// search can reach them.
module symbol_hash_table_resolver_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  shtr_pkg::shtr_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output shtr_pkg::shtr_rsp_type                rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [shtr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [shtr_pkg::CsrDataWidth-1:0]     csr_data
);

   logic                                  cache_ready_ff, cache_ready_in;
   logic [shtr_pkg::CfgCountWidth-1:0]    entry_count_ff, entry_count_in;
   logic [31:0]                           hash_ff, hash_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   shtr_pkg::shtr_rsp_type                rsp_data_ff, rsp_data_in;

   logic                                  req_accept;
   logic                                  ram_wr_en;
   shtr_pkg::shtr_entry_type              ram_wr_data;
   logic                                  ram_rd_en;
   logic [shtr_pkg::IdxWidth-1:0]         ram_rd_addr;
   shtr_pkg::shtr_entry_type              ram_rd_data;
   shtr_pkg::shtr_search_cmd_type         search_cmd;
   shtr_pkg::shtr_search_status_type      search_status;
   logic                                  out_free;

   assign req_ready  = search_status.idle;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // Slots beyond the table depth are dropped.
   assign ram_wr_en = req_accept && (req_data.kind == shtr_pkg::KindLoad)
                      && (32'(req_data.entry_index) < shtr_pkg::TableDepth);
   assign ram_wr_data = '{key: req_data.entry_hash, address: req_data.entry_address};

   always_comb begin
      hash_in          = hash_ff;
      search_cmd.start = 1'b0;
      search_cmd.key   = hash_ff;
      if (req_accept && (req_data.kind == shtr_pkg::KindName)) begin
         if (req_data.name_char != 8'd0) begin
            hash_in = (hash_ff << shtr_pkg::HashShift) + hash_ff
                      + 32'(req_data.name_char);
         end else begin
            search_cmd.start = 1'b1;
            hash_in          = shtr_pkg::HashSeed;
         end
      end
   end

   always_comb begin
      cache_ready_in = cache_ready_ff;
      entry_count_in = entry_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            shtr_pkg::CsrCacheReady: cache_ready_in = csr_data[0];
            shtr_pkg::CsrEntryCount: entry_count_in =
               shtr_pkg::CfgCountWidth'(csr_data);
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (search_status.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = search_status.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_ready_ff <= 1'b0;
         entry_count_ff <= '0;
         hash_ff        <= shtr_pkg::HashSeed;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cache_ready_ff <= cache_ready_in;
         entry_count_ff <= entry_count_in;
         hash_ff        <= hash_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   shtr_table_ram u_table_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (shtr_pkg::IdxWidth'(req_data.entry_index)),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   shtr_search u_search (
      .clock       (clock),
      .reset       (reset),
      .cmd         (search_cmd),
      .cache_ready (cache_ready_ff),
      .entry_count (entry_count_ff),
      .rd_en       (ram_rd_en),
      .rd_addr     (ram_rd_addr),
      .rd_data     (ram_rd_data),
      .out_free    (out_free),
      .status      (search_status)
   );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for symbol_hash_table_resolver_unit: loads sorted tables,
// sends symbol names byte by byte and checks every lookup against its own predictor.
// Depends on shtr_pkg and the resolver RTL only.
`timescale 1ns / 1ps

module tb_top;
   import shtr_pkg::*;

   localparam int LimitCycles  = 400000;
   localparam int SettleCycles = 40;
   localparam int DrainLimit   = 20000;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] address;
      logic [47:0] chars;
      logic [2:0]  len;
   } symbol_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   shtr_req_type             req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   shtr_rsp_type             rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   // Stimulus side.
   shtr_req_type request_backlog [$];
   symbol_type   catalog [TableDepth];
   int           catalog_size = 0;
   int           send_idle_pct = 37;
   int           recv_idle_pct = 37;
   int           rsp_stall_left = 0;
   int           cycle_count = 0;
   logic         req_taken = 1'b0;

   // Predictor side.
   logic [31:0]  key_mem [TableDepth];
   logic [31:0]  addr_mem [TableDepth];
   logic [31:0]  name_hash;
   logic         table_valid;
   logic [10:0]  slot_count;
   shtr_rsp_type expected_lookups [$];
   int           mismatch_count = 0;

   symbol_hash_table_resolver_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
      return (h << HashShift) + h + {24'h0, c};
   endfunction

   function automatic logic [31:0] name_key(input logic [47:0] chars, input int len);
      logic [31:0] h;
      h = HashSeed;
      for (int i = 0; i < len; i++) h = hash_step(h, chars[8*i +: 8]);
      return h;
   endfunction

   // Binary search over the configured number of slots, same probe order as the block.
   function automatic logic probe_table(input logic [31:0] key, output logic [31:0] addr);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = (slot_count > TableDepth) ? TableDepth : int'(slot_count);
      addr = NotFoundAddr;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (key_mem[mid] == key) begin
            addr = addr_mem[mid];
            return 1'b1;
         end
         if (key < key_mem[mid]) hi = mid;
         else lo = mid + 1;
      end
      return 1'b0;
   endfunction

   task automatic resolve_request(input shtr_req_type r);
      shtr_rsp_type verdict;
      logic [31:0]  hit_addr;
      if (r.kind == KindLoad) begin
         key_mem[r.entry_index]  = r.entry_hash;
         addr_mem[r.entry_index] = r.entry_address;
      end else if (r.name_char != 8'h00) begin
         name_hash = hash_step(name_hash, r.name_char);
      end else begin
         verdict.found = table_valid && probe_table(name_hash, hit_addr);
         verdict.symbol_address = verdict.found ? hit_addr : NotFoundAddr;
         expected_lookups.push_back(verdict);
         name_hash = HashSeed;
      end
   endtask

   task automatic report_mismatch(input string detail);
      $display("[%0t] MISMATCH: %s", $time, detail);
      mismatch_count++;
   endtask

   // Predictor: follows every accepted request and register write.
   always @(posedge clock) begin
      if (reset) begin
         name_hash = HashSeed;
         table_valid = 1'b0;
         slot_count = '0;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrCacheReady: table_valid = csr_data[0];
               CsrEntryCount: slot_count = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) resolve_request(req_data);
      end
   end

   // Monitor: compares each returned lookup with the oldest expectation.
   always @(posedge clock) begin
      shtr_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lookups.size() == 0) begin
            report_mismatch($sformatf("unexpected result address %h found %b",
                                      rsp_data.symbol_address, rsp_data.found));
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_data.symbol_address !== want.symbol_address)
               report_mismatch($sformatf("symbol_address got %h expected %h",
                                         rsp_data.symbol_address, want.symbol_address));
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found got %b expected %b",
                                         rsp_data.found, want.found));
         end
      end
   end

   // Driver: offers the next backlog request once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= request_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure, with an optional long hold-off.
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_load(input int slot, input logic [31:0] key, input logic [31:0] addr);
      shtr_req_type r;
      r.kind = KindLoad;
      r.entry_index = 10'(slot);
      r.entry_address = addr;
      r.entry_hash = key;
      r.name_char = 8'($urandom_range(255));
      request_backlog.push_back(r);
   endtask

   task automatic push_char(input logic [7:0] c);
      shtr_req_type r;
      r.kind = KindName;
      r.entry_index = 10'($urandom_range(TableDepth - 1));
      r.entry_address = $urandom;
      r.entry_hash = $urandom;
      r.name_char = c;
      request_backlog.push_back(r);
   endtask

   // A stray load in the middle of a name must leave the running hash alone.
   // Slots of the current table are rewritten with their own contents.
   task automatic push_stray_load();
      int slot;
      slot = $urandom_range(TableDepth - 1);
      if (slot < catalog_size) push_load(slot, catalog[slot].key, catalog[slot].address);
      else push_load(slot, $urandom, $urandom);
   endtask

   task automatic push_name(input logic [47:0] chars, input int len, input bit noisy);
      for (int i = 0; i < len; i++) begin
         push_char(chars[8*i +: 8]);
         if (noisy && $urandom_range(9) == 0) push_stray_load();
      end
      push_char(8'h00);
   endtask

   task automatic random_name(output logic [47:0] chars, output logic [2:0] len);
      len = ($urandom_range(3) == 0) ? 3'($urandom_range(4, 6)) : 3'($urandom_range(1, 3));
      chars = '0;
      for (int i = 0; i < len; i++) chars[8*i +: 8] = 8'($urandom_range(1, 255));
   endtask

   // Builds a sorted table of random names; equal hashes share one address so that
   // whichever duplicate the search lands on gives the same answer.
   task automatic build_catalog(input int n);
      symbol_type s;
      int j;
      for (int i = 0; i < n; i++) begin
         random_name(s.chars, s.len);
         s.key = name_key(s.chars, s.len);
         case ($urandom_range(15))
            0: s.address = 32'h0000_0000;
            1: s.address = 32'hFFFF_FFFF;
            default: s.address = $urandom;
         endcase
         j = i;
         while (j > 0 && catalog[j-1].key > s.key) begin
            catalog[j] = catalog[j-1];
            j--;
         end
         catalog[j] = s;
      end
      for (int i = 1; i < n; i++)
         if (catalog[i].key == catalog[i-1].key) catalog[i].address = catalog[i-1].address;
      catalog_size = n;
   endtask

   task automatic queue_table_loads();
      int order [TableDepth];
      int k;
      int swap;
      for (int i = 0; i < catalog_size; i++) order[i] = i;
      for (int i = catalog_size - 1; i > 0; i--) begin
         k = $urandom_range(i);
         swap = order[i];
         order[i] = order[k];
         order[k] = swap;
      end
      for (int i = 0; i < catalog_size; i++)
         push_load(order[i], catalog[order[i]].key, catalog[order[i]].address);
   endtask

   task automatic queue_lookups(input int count);
      logic [47:0] chars;
      logic [2:0]  len;
      int          pick;
      int          idx;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 60 && catalog_size > 0) begin
            idx = $urandom_range(catalog_size - 1);
            push_name(catalog[idx].chars, catalog[idx].len, 1'b1);
         end else if (pick < 88) begin
            random_name(chars, len);
            push_name(chars, len, 1'b1);
         end else begin
            push_name('0, 0, 1'b1);
         end
      end
   endtask

   task automatic wait_quiet(input int settle);
      while (request_backlog.size() != 0 || req_valid || expected_lookups.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int table_size, input int count, input int lookups,
                            input logic ready, input int stall);
      if (table_size > 0) build_catalog(table_size);
      wait_quiet(SettleCycles);
      write_csr(CsrCacheReady, CsrDataWidth'(ready));
      write_csr(CsrEntryCount, CsrDataWidth'(count));
      if (table_size > 0) queue_table_loads();
      queue_lookups(lookups / 2);
      // The sender pauses here until every lookup so far has been answered.
      wait_quiet(0);
      rsp_stall_left = stall;
      queue_lookups(lookups - lookups / 2);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < LimitCycles) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      int guard;
      shtr_rsp_type lost;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Out of reset the table is not ready and empty: every lookup misses.
      push_char(8'h00);
      push_name(48'h41, 1, 1'b0);
      wait_quiet(SettleCycles);
      write_csr(CsrCacheReady, 11'd1);
      push_name(48'hFF, 1, 1'b0);

      // Five sorted slots with the extreme keys at both ends.
      wait_quiet(SettleCycles);
      write_csr(CsrEntryCount, 11'd5);
      push_load(0, 32'h0000_0000, 32'h0000_0000);
      push_load(1, name_key(48'h01, 1), 32'hA5A5_5A5A);
      push_load(2, name_key(48'h61, 1), 32'hFFFF_FFFF);
      push_load(3, name_key(48'hFFFF, 2), 32'h0000_0001);
      push_load(4, 32'hFFFF_FFFF, 32'h8000_0000);
      push_char(8'h61);
      push_load(TableDepth - 1, $urandom, $urandom);
      push_char(8'h00);
      push_name(48'h01, 1, 1'b0);
      push_name(48'hFFFF, 2, 1'b0);
      push_char(8'h00);
      // A duplicate key, then an out-of-order slot that hides an existing name.
      push_load(1, name_key(48'h61, 1), 32'hFFFF_FFFF);
      push_load(3, 32'h0000_0001, 32'h0000_0001);
      push_name(48'hFFFF, 2, 1'b0);

      wait_quiet(SettleCycles);
      write_csr(CsrCacheReady, 11'd0);
      push_name(48'h61, 1, 1'b0);

      run_phase(1, 1, 6, 1'b1, 0);
      run_phase(2, 2, 6, 1'b1, 0);
      run_phase(3, 3, 6, 1'b1, 0);
      run_phase(16, 16, 10, 1'b0, 0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(40, 40, 16, 1'b1, 0);
      wait_quiet(0);
      send_idle_pct = 37;
      recv_idle_pct = 37;
      run_phase(TableDepth, TableDepth, 24, 1'b1, 300);
      run_phase(0, 2047, 14, 1'b1, 0);
      run_phase(0, 1000, 12, 1'b1, 0);

      guard = 0;
      while (guard < DrainLimit &&
             (request_backlog.size() != 0 || req_valid || expected_lookups.size() != 0)) begin
         @(posedge clock);
         guard++;
      end
      repeat (SettleCycles) @(posedge clock);
      while (expected_lookups.size() != 0) begin
         lost = expected_lookups.pop_front();
         report_mismatch($sformatf("no result for lookup expecting address %h found %b",
                                   lost.symbol_address, lost.found));
      end

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
